[hdl/max_flow_bfs_augmenting_macros.svh]
// Assertion macros shared by the max-flow block
`ifndef MAX_FLOW_BFS_AUGMENTING_MACROS_SVH
`define MAX_FLOW_BFS_AUGMENTING_MACROS_SVH
`ifndef SYNTHESIS
`define MF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MF_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MF_ASSERT(label, clk, rst_n, prop, msg)
`define MF_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[hdl/mfbfs_pkg.sv]
// Types and constants shared by the max-flow controller and datapath
package mfbfs_pkg;
  localparam int NUM_VERTICES = 8;
  localparam int CAP_BITS = 16;
  localparam int VTX_W = 3;
  localparam int IN_CAP_W = 16;
  localparam int FLOW_W = 19;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_COPY, ST_BFS_INIT, ST_BFS_POP, ST_BFS_SCAN,
    ST_NECK, ST_AUG_FWD, ST_AUG_REV, ST_DONE, ST_OUT
  } mf_state_t;

  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_SINK   = 1'b1;

  typedef struct packed {
    logic clear_step;  // advance clear sweep of capacity store
    logic copy_step;   // advance copy sweep
    logic bfs_init;
    logic bfs_pop;
    logic bfs_scan;
    logic neck_step;
    logic aug_fwd;
    logic aug_rev;
    logic flow_clear;
    logic out_load;
  } mf_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic queue_empty;
    logic scan_hit_sink;
    logic scan_done;
    logic walk_done;
    logic step_odd;    // second phase of a read step, when the read data is valid
    logic trivial;
  } mf_status_t;
endpackage

[hdl/mfbfs_ram.sv]
// Generic single-port-write, one-read RAM with registered read data
module mfbfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/mfbfs_ctrl.sv]
// Controller state machine of the max-flow block
`include "max_flow_bfs_augmenting_macros.svh"
module mfbfs_ctrl
  import mfbfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       out_taken,
  input  mf_status_t sts,
  output mf_cmd_t    cmd,
  output logic       loading,
  output logic       out_valid
);
  mf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (start) state_nxt = ST_COPY;
      ST_CLEAR:    if (sts.sweep_done) state_nxt = ST_LOAD;
      ST_COPY: begin
        if (sts.trivial) state_nxt = ST_DONE;
        else if (sts.sweep_done) state_nxt = ST_BFS_INIT;
      end
      ST_BFS_INIT: state_nxt = ST_BFS_POP;
      ST_BFS_POP:  state_nxt = sts.queue_empty ? ST_DONE : ST_BFS_SCAN;
      ST_BFS_SCAN: begin
        if (sts.scan_hit_sink) state_nxt = ST_NECK;
        else if (sts.scan_done) state_nxt = ST_BFS_POP;
      end
      ST_NECK:     if (sts.walk_done) state_nxt = ST_AUG_FWD;
      ST_AUG_FWD:  if (sts.step_odd) state_nxt = ST_AUG_REV;
      ST_AUG_REV:  if (sts.step_odd) state_nxt = sts.walk_done ? ST_BFS_INIT : ST_AUG_FWD;
      ST_DONE:     state_nxt = ST_OUT;
      ST_OUT:      if (out_taken) state_nxt = ST_CLEAR;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    loading = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD:     loading = 1'b1;
      ST_CLEAR:    cmd.clear_step = 1'b1;
      ST_COPY:     cmd.copy_step = 1'b1;
      ST_BFS_INIT: cmd.bfs_init = 1'b1;
      ST_BFS_POP:  cmd.bfs_pop = 1'b1;
      ST_BFS_SCAN: cmd.bfs_scan = 1'b1;
      ST_NECK:     cmd.neck_step = 1'b1;
      ST_AUG_FWD:  cmd.aug_fwd = 1'b1;
      ST_AUG_REV:  cmd.aug_rev = 1'b1;
      ST_DONE:     cmd.out_load = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.flow_clear = out_taken;
      end
      default:     cmd = '0;
    endcase
  end

  `MF_ASSERT(a_start_only_loading, clk, rst_n, start |-> state_r == ST_LOAD, "start outside load")
  `MF_ASSERT(a_out_holds, clk, rst_n, (out_valid && !out_taken) |=> out_valid, "result dropped")
  `MF_ASSERT(a_done_to_out, clk, rst_n, state_r == ST_DONE |=> out_valid, "result not shown")
endmodule

[hdl/mfbfs_dp.sv]
// Datapath of the max-flow block: stores, queue, search and augment logic
module mfbfs_dp
  import mfbfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  mf_cmd_t             cmd,
  input  logic                load_we,
  input  logic [VTX_W-1:0]    load_from,
  input  logic [VTX_W-1:0]    load_to,
  input  logic [IN_CAP_W-1:0] load_cap,
  input  logic [VTX_W-1:0]    src_v,
  input  logic [VTX_W-1:0]    snk_v,
  output mf_status_t          sts,
  output logic [FLOW_W-1:0]   flow_out
);
  localparam int NV = NUM_VERTICES;
  localparam int CB = CAP_BITS;
  localparam int VB = (NV > 1) ? $clog2(NV) : 1;
  localparam int AB = 2 * VB;
  localparam int DEPTH = NV * NV;
  localparam int RB = CB + 1;
  localparam int FTW = CB + VB + 2;

  // sweep counter over all entries, one wider to hold the depth
  logic [AB:0] sw_r, sw_nxt;
  logic        sw_pend_r;
  // bfs state
  logic [NV-1:0]  vis_r;
  logic [VB-1:0]  par_r [NV];
  logic [VB-1:0]  q_r   [NV];
  logic [VB:0]    qh_r, qt_r;
  logic [VB-1:0]  u_r;
  logic [VB:0]    w_r;
  logic           rd_ok_r;
  logic [VB-1:0]  walk_r;
  logic [RB-1:0]  neck_r;
  logic [FTW-1:0] flow_r;
  logic [FLOW_W-1:0] out_r;
  logic           phase_r;

  logic [VB-1:0] src, snk;
  assign src = VB'(src_v);
  assign snk = VB'(snk_v);
  logic bad;
  assign bad = (32'(src_v) >= NV) || (32'(snk_v) >= NV) || (src_v == snk_v);

  // capacity store
  logic          c_we;
  logic [AB-1:0] c_wa, c_ra;
  logic [CB-1:0] c_wd, c_rd;
  // residual store
  logic          r_we;
  logic [AB-1:0] r_wa, r_ra;
  logic [RB-1:0] r_wd, r_rd;

  mfbfs_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_cap (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );
  mfbfs_ram #(.WIDTH(RB), .DEPTH(DEPTH)) u_res (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd)
  );

  logic [VB-1:0] pw, w_lo;
  assign pw = par_r[walk_r];
  assign w_lo = w_r[VB-1:0];

  always_comb begin
    c_we = 1'b0; c_wa = '0; c_wd = '0;
    r_we = 1'b0; r_wa = '0; r_wd = '0;
    c_ra = sw_r[AB-1:0];
    r_ra = {u_r, w_lo};
    if (load_we) begin
      c_we = 1'b1; c_wa = {load_from[VB-1:0], load_to[VB-1:0]}; c_wd = load_cap[CB-1:0];
    end else if (cmd.clear_step) begin
      c_we = !sw_r[AB]; c_wa = sw_r[AB-1:0];
    end
    if (cmd.copy_step) begin
      r_we = sw_pend_r; r_wa = sw_nxt[AB-1:0] - AB'(1); r_wd = {1'b0, c_rd};
      c_ra = sw_r[AB-1:0];
    end
    if (cmd.neck_step) r_ra = {pw, walk_r};
    if (cmd.aug_fwd) begin
      r_ra = {walk_r, pw};
      if (phase_r) begin
        r_we = 1'b1; r_wa = {pw, walk_r}; r_wd = r_rd - neck_r;
      end else r_ra = {pw, walk_r};
    end
    if (cmd.aug_rev) begin
      r_we = phase_r; r_wa = {walk_r, pw}; r_wd = r_rd + neck_r;
      r_ra = {walk_r, pw};
    end
  end

  assign sw_nxt = sw_r;

  logic hit;
  assign hit = rd_ok_r && !vis_r[w_lo] && (r_rd != '0) && !w_r[VB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= '0; sw_pend_r <= 1'b0; vis_r <= '0; flow_r <= '0;
      qh_r <= '0; qt_r <= '0; rd_ok_r <= 1'b0; phase_r <= 1'b0;
    end else begin
      if (cmd.clear_step) sw_r <= sw_r[AB] ? '0 : sw_r + 1'b1;
      // hold the sweep at zero when no search follows
      if (cmd.copy_step && !bad) begin
        sw_pend_r <= !sw_r[AB];
        sw_r <= sw_r[AB] ? '0 : sw_r + 1'b1;
      end
      if (cmd.bfs_init) begin
        vis_r <= NV'(1) << src; par_r[src] <= src;
        q_r[0] <= src; qh_r <= '0; qt_r <= (VB+1)'(1);
      end
      if (cmd.bfs_pop && qh_r != qt_r) begin
        u_r <= q_r[qh_r[VB-1:0]]; qh_r <= qh_r + 1'b1;
        w_r <= '0; rd_ok_r <= 1'b0;
      end
      if (cmd.bfs_scan) begin
        // address w_r issued; the RAM returns its data in the next cycle
        if (!rd_ok_r) begin
          rd_ok_r <= 1'b1;
        end else begin
          if (hit) begin
            par_r[w_lo] <= u_r;
            vis_r[w_lo] <= 1'b1;
            if (32'(qt_r) < NV) begin
              q_r[qt_r[VB-1:0]] <= w_lo; qt_r <= qt_r + 1'b1;
            end
          end
          rd_ok_r <= 1'b0;
          w_r <= w_r + 1'b1;
          if (hit && w_lo == snk) begin
            walk_r <= snk; neck_r <= '1; phase_r <= 1'b0;
          end
        end
      end
      if (cmd.neck_step) begin
        phase_r <= !phase_r;
        if (phase_r) begin
          if (r_rd < neck_r) neck_r <= r_rd;
          if (pw == src) walk_r <= snk;
          else walk_r <= pw;
        end
      end
      if (cmd.aug_fwd) phase_r <= !phase_r;
      if (cmd.aug_rev) begin
        if (phase_r) begin
          phase_r <= 1'b0;
          walk_r <= pw;
          if (pw == src) flow_r <= flow_r + FTW'(neck_r);
        end
        else phase_r <= 1'b1;
      end
      if (cmd.flow_clear) flow_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= bad ? '0 : flow_r[FLOW_W-1:0];
  end
  assign flow_out = out_r;

  always_comb begin
    sts = '0;
    sts.sweep_done = sw_r[AB] && (cmd.clear_step || sw_pend_r);
    sts.queue_empty = (qh_r == qt_r);
    sts.scan_hit_sink = rd_ok_r && hit && (w_lo == snk);
    sts.scan_done = rd_ok_r && (w_lo == VB'(NV - 1) || w_r[VB]);
    sts.walk_done = phase_r && (pw == src);
    sts.step_odd = phase_r;
    sts.trivial = bad;
  end
endmodule

[hdl/max_flow_bfs_augmenting.sv]
// Top level of the breadth-first augmenting-path max-flow block
// Edge words are taken one per cycle while the block is loading; a word that
// names a vertex beyond the graph is dropped, though its last_entry flag still
// starts the search. The word with last_entry set is stored, then the capacity
// store is copied to the residual store and searches repeat: each search is
// started, takes vertices from the queue and scans their neighbours (the scan
// stops at the sink), and for a found path walks its edges for the bottleneck
// and then updates them, all bounded by the single residual RAM port.
// After the last search fails, the result word is loaded, then offered and
// held until taken. After the result word is taken, and after reset, the
// capacity store is cleared by a sweep during which no word is accepted. A
// source or sink equal or out of range skips the search and gives a result of 0.
module max_flow_bfs_augmenting
  import mfbfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VTX_W-1:0]    in_from_vertex,
  input  logic [VTX_W-1:0]    in_to_vertex,
  input  logic [IN_CAP_W-1:0] in_edge_capacity,
  input  logic                in_last_entry,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FLOW_W-1:0]   out_net_flow,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [VTX_W-1:0]    cfg_data
);
  logic [VTX_W-1:0] src_r, snk_r;
  mf_cmd_t cmd;
  mf_status_t sts;
  logic loading, acc;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
      snk_r <= 3'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SOURCE: src_r <= cfg_data;
        CFG_SINK:   snk_r <= cfg_data;
        default:    src_r <= src_r;
      endcase
    end
  end

  assign in_stall = !loading;
  assign acc = in_valid && loading;

  // drop loads naming a vertex beyond the graph
  logic in_rng;
  assign in_rng = (32'(in_from_vertex) < NUM_VERTICES) && (32'(in_to_vertex) < NUM_VERTICES);

  mfbfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(acc && in_last_entry),
    .out_taken(out_valid && !out_stall), .sts(sts), .cmd(cmd),
    .loading(loading), .out_valid(out_valid)
  );

  mfbfs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .load_we(acc && in_rng),
    .load_from(in_from_vertex), .load_to(in_to_vertex),
    .load_cap(in_edge_capacity), .src_v(src_r), .snk_v(snk_r),
    .sts(sts), .flow_out(out_net_flow)
  );
endmodule

[tb/max_flow_bfs_augmenting_tb.sv]
// Testbench for the breadth-first augmenting-path max-flow block
module max_flow_bfs_augmenting_tb;
  import mfbfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 8;
  localparam int WATCHDOG_LIMIT = 200000;

  // Golden max-flow calculator with its own copy of the graph and config
  class flow_scoreboard;
    logic [15:0] cap_grid [NV*NV];
    logic [VTX_W-1:0] src_sel;
    logic [VTX_W-1:0] snk_sel;
    logic [FLOW_W-1:0] pending_flows [$];
    int mismatches;

    function new();
      foreach (cap_grid[k]) cap_grid[k] = '0;
      src_sel = 3'd0;
      snk_sel = 3'd7;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [VTX_W-1:0] val);
      if (idx == CFG_SOURCE) src_sel = val;
      else snk_sel = val;
    endfunction

    // Run breadth-first augmentation on a residual copy of the graph
    function logic [FLOW_W-1:0] solve_flow();
      longint resid [NV*NV];
      bit seen [NV];
      int parent [NV];
      int fifo [NV];
      int qh, qt, u, w, v;
      longint neck, total;
      bit reached;
      total = 0;
      if (src_sel == snk_sel) return '0;
      foreach (resid[k]) resid[k] = cap_grid[k];
      forever begin
        foreach (seen[k]) seen[k] = 0;
        qh = 0; qt = 0; reached = 0;
        fifo[qt++] = src_sel;
        seen[src_sel] = 1;
        parent[src_sel] = src_sel;
        while (qh < qt && !reached) begin
          u = fifo[qh++];
          for (w = 0; w < NV && !reached; w++) begin
            if (!seen[w] && resid[u*NV+w] > 0) begin
              parent[w] = u;
              if (w == snk_sel) reached = 1;
              else begin
                seen[w] = 1;
                if (qt < NV) fifo[qt++] = w;
              end
            end
          end
        end
        if (!reached) break;
        neck = 64'h7fff_ffff_ffff_ffff;
        for (v = snk_sel; v != src_sel; v = parent[v])
          if (resid[parent[v]*NV+v] < neck) neck = resid[parent[v]*NV+v];
        for (v = snk_sel; v != src_sel; v = parent[v]) begin
          resid[parent[v]*NV+v] -= neck;
          resid[v*NV+parent[v]] += neck;
        end
        total += neck;
      end
      return total[FLOW_W-1:0];
    endfunction

    function void note_edge(logic [2:0] f, logic [2:0] t, logic [15:0] c, logic lst);
      cap_grid[f*NV+t] = c;
      if (lst) begin
        pending_flows.push_back(solve_flow());
        foreach (cap_grid[k]) cap_grid[k] = '0;
      end
    endfunction

    task check_flow(logic [FLOW_W-1:0] got);
      logic [FLOW_W-1:0] want;
      if (pending_flows.size() == 0) begin
        report_mismatch($sformatf("unexpected flow word %0d", got));
        return;
      end
      want = pending_flows.pop_front();
      if (got !== want)
        report_mismatch($sformatf("flow got %0d want %0d", got, want));
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_entry;
  logic [VTX_W-1:0] in_from_vertex, in_to_vertex;
  logic [IN_CAP_W-1:0] in_edge_capacity;
  logic out_valid, out_stall;
  logic [FLOW_W-1:0] out_net_flow;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [VTX_W-1:0] cfg_data;

  flow_scoreboard flow_sb;
  bit idle_free;     // no idling on either side while set
  bit hold_off_req;  // ask the receiver for one long hold-off
  int quiet_cycles;

  max_flow_bfs_augmenting dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: count cycles with no handshake on any of the three channels
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("max_flow_bfs_augmenting verification failed");
      $finish;
    end
  end

  // Result side: sample at the rising edge, change stall at the falling edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) flow_sb.check_flow(out_net_flow);
  end

  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        // hold off long enough for the block to fill and stall its input
        for (hold = 0; hold < 400; hold++) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !idle_free && ($urandom_range(99) < 9);
      end
    end
  end

  // Offer one edge word and hold it until accepted; the next call may drop valid
  // for a random idle gap, and a drain drops it
  task automatic send_edge(logic [2:0] f, logic [2:0] t, logic [15:0] c, logic lst);
    while (!idle_free && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_from_vertex <= f;
    in_to_vertex <= t;
    in_edge_capacity <= c;
    in_last_entry <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    flow_sb.note_edge(f, t, c, lst);
    @(negedge clk);
  endtask

  // Write source then sink, one word each
  task automatic write_ends(logic [VTX_W-1:0] s, logic [VTX_W-1:0] k);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SOURCE;
    cfg_data <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    flow_sb.set_reg(CFG_SOURCE, s);
    @(negedge clk);
    cfg_index <= CFG_SINK;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    flow_sb.set_reg(CFG_SINK, k);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every flow word, then let the clearing sweep finish
  task automatic drain_block();
    int n;
    in_valid <= 1'b0;
    while (flow_sb.pending_flows.size() != 0) @(negedge clk);
    for (n = 0; n < 2*NV*NV + 20; n++) @(negedge clk);
  endtask

  // Random graph: mostly a few edges with broad capacities
  task automatic send_graph(int edges, bit dense_caps);
    int e;
    logic [15:0] c;
    for (e = 0; e < edges; e++) begin
      case ($urandom_range(3))
        0: c = 16'($urandom_range(65535));
        1: c = 16'($urandom_range(20));
        2: c = dense_caps ? 16'hffff : 16'($urandom_range(1000));
        default: c = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(255));
      endcase
      send_edge(3'($urandom_range(7)), 3'($urandom_range(7)), c, e == edges - 1);
    end
  endtask

  initial begin : stimulus
    int p, g;
    flow_sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0; in_from_vertex = '0; in_to_vertex = '0;
    in_edge_capacity = '0; in_last_entry = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_SOURCE; cfg_data = '0;
    idle_free = 1'b0; hold_off_req = 1'b0;
    quiet_cycles = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default source 0 / sink 7, full-width chain and parallel paths
    send_edge(3'd0, 3'd7, 16'hffff, 1'b0);
    send_edge(3'd0, 3'd1, 16'hffff, 1'b0);
    send_edge(3'd1, 3'd7, 16'hffff, 1'b0);
    send_edge(3'd3, 3'd3, 16'd50, 1'b0);   // self loop carries nothing
    send_edge(3'd5, 3'd0, 16'd40, 1'b0);   // edge into the source
    send_edge(3'd0, 3'd1, 16'd0, 1'b1);    // overwrite with zero, then solve
    // Empty graph: only a zero edge
    send_edge(3'd7, 3'd0, 16'd0, 1'b1);
    // Two paths to the sink with a cross edge between them
    send_edge(3'd0, 3'd1, 16'd10, 1'b0);
    send_edge(3'd0, 3'd2, 16'd10, 1'b0);
    send_edge(3'd1, 3'd2, 16'd10, 1'b0);
    send_edge(3'd1, 3'd7, 16'd10, 1'b0);
    send_edge(3'd2, 3'd7, 16'd10, 1'b1);
    // Every vertex fully meshed at maximum capacity
    for (p = 0; p < NV*NV; p++)
      send_edge(3'(p / NV), 3'(p % NV), 16'hffff, p == NV*NV - 1);
    drain_block();

    // Source equals sink gives zero
    write_ends(3'd4, 3'd4);
    send_edge(3'd4, 3'd5, 16'd9, 1'b0);
    send_edge(3'd5, 3'd4, 16'd9, 1'b1);
    drain_block();
    // Reversed extremes
    write_ends(3'd7, 3'd0);
    send_edge(3'd7, 3'd0, 16'd1, 1'b0);
    send_edge(3'd7, 3'd6, 16'd300, 1'b0);
    send_edge(3'd6, 3'd0, 16'd200, 1'b1);
    drain_block();

    // Random phases with changing source and sink
    for (p = 0; p < 8; p++) begin
      write_ends((p == 0) ? 3'd0 : 3'($urandom_range(7)),
                 (p == 0) ? 3'd7 : 3'($urandom_range(7)));
      idle_free = (p == 3);
      for (g = 0; g < 18; g++) begin
        if (p == 5 && g == 2) hold_off_req = 1'b1;
        send_graph($urandom_range(12) == 0 ? 20 : $urandom_range(1, 10), p == 6);
      end
      drain_block();
    end
    idle_free = 1'b0;

    if (flow_sb.mismatches == 0)
      $display("max_flow_bfs_augmenting verification clean");
    else
      $display("max_flow_bfs_augmenting verification failed");
    $finish;
  end
endmodule
